### design/qie_pkg.sv
`timescale 1ns / 1ps
// Shared types, sizes and the microcode store of the quad instruction executor.
// Depends on nothing; the channel interfaces and the top level import it.
package qie_pkg;

  localparam int REG_COUNT     = 128;
  localparam int ADDRESS_WIDTH = 16;
  localparam int REG_IDX_W     = $clog2(REG_COUNT);
  localparam int DATA_W        = 32;
  localparam int MODE_W        = 4;
  localparam int DEST_W        = 16;
  localparam int OPB_W         = 7;
  localparam int OUT_ADDR_W    = 16;
  localparam int DIV_CNT_W     = $clog2(DATA_W + 1);

  localparam logic [DATA_W-1:0]    REG_COUNT_U = DATA_W'(REG_COUNT);
  localparam logic [DIV_CNT_W-1:0] DIV_STEPS   = DIV_CNT_W'(DATA_W);

  typedef enum logic [MODE_W-1:0] {
    OP_ADD     = 4'd0,
    OP_SUB     = 4'd1,
    OP_MUL     = 4'd2,
    OP_DIV     = 4'd3,
    OP_LOADINT = 4'd4,
    OP_PRINT   = 4'd5,
    OP_EXIT    = 4'd6,
    OP_IF_EQ   = 4'd7,
    OP_GOTO    = 4'd8
  } opcode_t;

  // Microprogram addresses.
  typedef enum logic [3:0] {
    U_FETCH    = 4'd0,
    U_DECODE   = 4'd1,
    U_ADD      = 4'd2,
    U_SUB      = 4'd3,
    U_MUL      = 4'd4,
    U_LOADINT  = 4'd5,
    U_DIV_INIT = 4'd6,
    U_DIV_STEP = 4'd7,
    U_DIV_DONE = 4'd8,
    U_PRINT    = 4'd9,
    U_EXIT     = 4'd10,
    U_IF_EQ    = 4'd11,
    U_GOTO     = 4'd12,
    U_NOP      = 4'd13,
    U_STOPPED  = 4'd14
  } upc_t;

  // Sequencing of the step counter.
  typedef enum logic [2:0] {
    SEQ_WAIT_IN,   // hold until a transaction is taken, then go to target
    SEQ_DISPATCH,  // jump to the routine of the latched opcode
    SEQ_JUMP,      // go to target
    SEQ_LOOP,      // repeat this step until the divide count runs out
    SEQ_FINISH     // hold until the output register is free, then go to target
  } seq_t;

  typedef enum logic [2:0] {
    RES_ADD,
    RES_SUB,
    RES_MUL,
    RES_IMM,
    RES_QUO
  } res_t;

  typedef enum logic [1:0] {
    PC_INC,
    PC_HOLD,
    PC_BRANCH,
    PC_COND
  } pc_sel_t;

  typedef struct packed {
    seq_t    seq;
    res_t    res;
    logic    wr;
    logic    div_init;
    logic    div_step;
    logic    print;
    logic    halt;
    logic    dz_chk;
    pc_sel_t pc_sel;
    upc_t    target;
  } ctl_t;

  function automatic ctl_t ucode(input upc_t addr);
    ctl_t c;
    begin
      c = '{seq: SEQ_JUMP, res: RES_ADD, wr: 1'b0, div_init: 1'b0, div_step: 1'b0,
            print: 1'b0, halt: 1'b0, dz_chk: 1'b0, pc_sel: PC_INC, target: U_FETCH};
      case (addr)
        U_FETCH: begin
          c.seq    = SEQ_WAIT_IN;
          c.target = U_DECODE;
        end
        U_DECODE:   c.seq = SEQ_DISPATCH;
        U_ADD: begin
          c.seq = SEQ_FINISH;
          c.res = RES_ADD;
          c.wr  = 1'b1;
        end
        U_SUB: begin
          c.seq = SEQ_FINISH;
          c.res = RES_SUB;
          c.wr  = 1'b1;
        end
        U_MUL: begin
          c.seq = SEQ_FINISH;
          c.res = RES_MUL;
          c.wr  = 1'b1;
        end
        U_LOADINT: begin
          c.seq = SEQ_FINISH;
          c.res = RES_IMM;
          c.wr  = 1'b1;
        end
        U_DIV_INIT: begin
          c.div_init = 1'b1;
          c.target   = U_DIV_STEP;
        end
        U_DIV_STEP: begin
          c.seq      = SEQ_LOOP;
          c.div_step = 1'b1;
          c.target   = U_DIV_DONE;
        end
        U_DIV_DONE: begin
          c.seq    = SEQ_FINISH;
          c.res    = RES_QUO;
          c.wr     = 1'b1;
          c.dz_chk = 1'b1;
        end
        U_PRINT: begin
          c.seq   = SEQ_FINISH;
          c.print = 1'b1;
        end
        U_EXIT: begin
          c.seq    = SEQ_FINISH;
          c.halt   = 1'b1;
          c.pc_sel = PC_HOLD;
        end
        U_IF_EQ: begin
          c.seq    = SEQ_FINISH;
          c.pc_sel = PC_COND;
        end
        U_GOTO: begin
          c.seq    = SEQ_FINISH;
          c.pc_sel = PC_BRANCH;
        end
        U_NOP:      c.seq = SEQ_FINISH;
        U_STOPPED: begin
          c.seq    = SEQ_FINISH;
          c.pc_sel = PC_HOLD;
        end
        default:    c.seq = SEQ_JUMP;
      endcase
      return c;
    end
  endfunction

  // Entry point of the routine for one instruction.
  function automatic upc_t dispatch(input logic stopped, input logic [MODE_W-1:0] mode);
    upc_t entry;
    begin
      if (stopped) begin
        entry = U_STOPPED;
      end else begin
        case (opcode_t'(mode))
          OP_ADD:     entry = U_ADD;
          OP_SUB:     entry = U_SUB;
          OP_MUL:     entry = U_MUL;
          OP_DIV:     entry = U_DIV_INIT;
          OP_LOADINT: entry = U_LOADINT;
          OP_PRINT:   entry = U_PRINT;
          OP_EXIT:    entry = U_EXIT;
          OP_IF_EQ:   entry = U_IF_EQ;
          OP_GOTO:    entry = U_GOTO;
          default:    entry = U_NOP;
        endcase
      end
      return entry;
    end
  endfunction

endpackage

### design/qie_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for instructions in and results out.
// Depends on qie_pkg for the field widths.
interface qie_in_if import qie_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [MODE_W-1:0]        mode;
  logic [DEST_W-1:0]        dest;
  logic signed [DATA_W-1:0] first_operand;
  logic [OPB_W-1:0]         second_operand;

  modport source (output valid, mode, dest, first_operand, second_operand, input ready);
  modport sink   (input valid, mode, dest, first_operand, second_operand, output ready);
endinterface

interface qie_out_if import qie_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [OUT_ADDR_W-1:0]    next_address;
  logic                     print_valid;
  logic signed [DATA_W-1:0] print_value;
  logic                     halted;
  logic                     divide_by_zero;

  modport source (output valid, next_address, print_valid, print_value, halted,
                  divide_by_zero, input ready);
  modport sink   (input valid, next_address, print_valid, print_value, halted,
                  divide_by_zero, output ready);
endinterface

### design/quad_instruction_executor.sv
`timescale 1ns / 1ps
// Top level of the quad instruction executor: microcoded sequencer, register file,
// divider and output register. Depends on qie_pkg and the interfaces in qie_if.sv.

// The executor runs one three-address instruction per input transaction against a
// 128-entry, 32-bit register file and a 16-bit program counter, and answers every
// instruction with exactly one result transaction: the new program counter, an
// optional printed value, the halt status and a divide-by-zero flag. The host fetches
// the instruction at next_address and sends it as the next transaction. Control comes
// from a small microprogram in a read-only table; each instruction passes through a
// fetch step, a decode step and then its routine, and its result is loaded into the
// output register when the routine finishes. Division runs a restoring divider one
// quotient bit per cycle: a setup step, 32 divide steps and a final write; that loop
// sets the worst-case rate. The next instruction is accepted as soon as the result is
// loaded into the output register, even while that result still waits to be taken; a
// routine that reaches its final step while the previous result is still unclaimed
// waits for as long as that result stays stalled. After reset the register file reads
// as all zero at once: a valid bit per entry masks entries never written, so no
// clearing pass is needed. After an exit instruction every further instruction is
// answered with the held counter and halted set.
module quad_instruction_executor
  import qie_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  qie_in_if.sink    in_ch,
  qie_out_if.source out_ch
);

  // Sequencer state.
  upc_t upc;
  upc_t upc_next;
  ctl_t ctl;

  // Architectural state.
  logic [ADDRESS_WIDTH-1:0] pc;
  logic [ADDRESS_WIDTH-1:0] pc_next;
  logic                     stopped;

  // Latched instruction and operand lookup.
  logic [MODE_W-1:0]        mode_q;
  logic [DEST_W-1:0]        dest_q;
  logic [DATA_W-1:0]        imm_q;
  logic                     dest_ok_q;
  logic                     x_ok_q;
  logic                     y_ok_q;
  logic [DATA_W-1:0]        rd_x;
  logic [DATA_W-1:0]        rd_y;
  logic [DATA_W-1:0]        x;
  logic [DATA_W-1:0]        y;

  // Register file: memory plus a valid bit per entry that reset clears.
  logic [DATA_W-1:0]        regs [REG_COUNT];
  logic [REG_COUNT-1:0]     vld;
  logic [REG_IDX_W-1:0]     idx_x;
  logic [REG_IDX_W-1:0]     idx_y;
  logic                     x_in_range;
  logic                     y_in_range;

  // Divider.
  logic [DATA_W-1:0]        quo;
  logic [DATA_W-1:0]        rem;
  logic [DATA_W-1:0]        dvsr;
  logic                     quo_neg;
  logic [DIV_CNT_W-1:0]     div_cnt;
  logic [DATA_W:0]          div_shift;
  logic [DATA_W:0]          div_diff;

  // Output register.
  logic                     out_valid;
  logic [OUT_ADDR_W-1:0]    next_address;
  logic                     print_valid;
  logic [DATA_W-1:0]        print_value;
  logic                     halted;
  logic                     divide_by_zero;

  logic                     accept;
  logic                     fire;
  logic                     wr_fire;
  logic [DATA_W-1:0]        wd;
  logic [ADDRESS_WIDTH-1:0] pc_inc;
  logic [ADDRESS_WIDTH-1:0] branch_target;
  logic                     y_zero;

  assign ctl = ucode(upc);

  // A transaction is only taken in the fetch step, and a routine only finishes
  // when the output register is empty or being emptied in this cycle.
  assign in_ch.ready = (ctl.seq == SEQ_WAIT_IN);
  assign accept      = in_ch.valid && in_ch.ready;
  assign fire        = (ctl.seq == SEQ_FINISH) && (!out_valid || out_ch.ready);
  assign wr_fire     = fire && ctl.wr && dest_ok_q;

  // A negative first operand is above every index when seen as unsigned.
  assign x_in_range = $unsigned(in_ch.first_operand) < REG_COUNT_U;
  assign y_in_range = DATA_W'(in_ch.second_operand) < REG_COUNT_U;
  assign idx_x      = in_ch.first_operand[REG_IDX_W-1:0];
  assign idx_y      = REG_IDX_W'(in_ch.second_operand);

  // Sources out of range and entries never written read as zero.
  assign x = x_ok_q ? rd_x : '0;
  assign y = y_ok_q ? rd_y : '0;
  assign y_zero = (y == '0);

  assign div_shift = {rem, quo[DATA_W-1]};
  assign div_diff  = div_shift - {1'b0, dvsr};

  always_comb begin
    case (ctl.res)
      RES_ADD: wd = x + y;
      RES_SUB: wd = x - y;
      RES_MUL: wd = x * y;
      RES_IMM: wd = imm_q;
      RES_QUO: wd = y_zero ? '0 : (quo_neg ? (-quo) : quo);
      default: wd = '0;
    endcase
  end

  assign pc_inc        = pc + 1'b1;
  assign branch_target = ADDRESS_WIDTH'(dest_q);

  always_comb begin
    case (ctl.pc_sel)
      PC_INC:    pc_next = pc_inc;
      PC_HOLD:   pc_next = pc;
      PC_BRANCH: pc_next = branch_target;
      PC_COND:   pc_next = (x == y) ? branch_target : pc_inc;
      default:   pc_next = pc_inc;
    endcase
  end

  always_comb begin
    case (ctl.seq)
      SEQ_WAIT_IN:  upc_next = accept ? ctl.target : upc;
      SEQ_DISPATCH: upc_next = dispatch(stopped, mode_q);
      SEQ_JUMP:     upc_next = ctl.target;
      SEQ_LOOP:     upc_next = (div_cnt == DIV_CNT_W'(1)) ? ctl.target : upc;
      SEQ_FINISH:   upc_next = fire ? ctl.target : upc;
      default:      upc_next = U_FETCH;
    endcase
  end

  // Sequencer, architectural state and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      upc       <= U_FETCH;
      pc        <= '0;
      stopped   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      upc <= upc_next;
      if (fire) begin
        pc        <= pc_next;
        stopped   <= stopped | ctl.halt;
        out_valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Result payload; loaded together with out_valid.
  always_ff @(posedge clk) begin
    if (fire) begin
      next_address   <= OUT_ADDR_W'(pc_next);
      print_valid    <= ctl.print;
      print_value    <= ctl.print ? x : '0;
      halted         <= stopped | ctl.halt;
      divide_by_zero <= ctl.dz_chk && y_zero;
    end
  end

  // Instruction latch and register file reads, both taken with the transaction.
  always_ff @(posedge clk) begin
    if (accept) begin
      mode_q    <= in_ch.mode;
      dest_q    <= in_ch.dest;
      imm_q     <= in_ch.first_operand;
      dest_ok_q <= DATA_W'(in_ch.dest) < REG_COUNT_U;
      x_ok_q    <= x_in_range && vld[idx_x];
      y_ok_q    <= y_in_range && vld[idx_y];
      rd_x      <= regs[idx_x];
      rd_y      <= regs[idx_y];
    end
    if (wr_fire) begin
      regs[dest_q[REG_IDX_W-1:0]] <= wd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (wr_fire) begin
      vld[dest_q[REG_IDX_W-1:0]] <= 1'b1;
    end
  end

  // Restoring divider on magnitudes; the sign is fixed when the quotient is written.
  always_ff @(posedge clk) begin
    if (rst) begin
      div_cnt <= '0;
    end else if (ctl.div_init) begin
      div_cnt <= DIV_STEPS;
    end else if (ctl.div_step) begin
      div_cnt <= div_cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.div_init) begin
      quo     <= x[DATA_W-1] ? (-x) : x;
      dvsr    <= y[DATA_W-1] ? (-y) : y;
      rem     <= '0;
      quo_neg <= x[DATA_W-1] ^ y[DATA_W-1];
    end else if (ctl.div_step) begin
      if (!div_diff[DATA_W]) begin
        rem <= div_diff[DATA_W-1:0];
        quo <= {quo[DATA_W-2:0], 1'b1};
      end else begin
        rem <= div_shift[DATA_W-1:0];
        quo <= {quo[DATA_W-2:0], 1'b0};
      end
    end
  end

  assign out_ch.valid          = out_valid;
  assign out_ch.next_address   = next_address;
  assign out_ch.print_valid    = print_valid;
  assign out_ch.print_value    = print_value;
  assign out_ch.halted         = halted;
  assign out_ch.divide_by_zero = divide_by_zero;

`ifndef NO_ASSERTIONS
  // An accepted instruction always moves on to decode.
  a_accept_decodes: assert property (@(posedge clk) disable iff (rst)
    accept |=> (upc == U_DECODE))
    else $error("accepted instruction did not reach decode");

  // Once halted, the executor stays halted until reset.
  a_halt_sticks: assert property (@(posedge clk) disable iff (rst)
    stopped |=> stopped)
    else $error("halt state was lost");

  // The program counter cannot move while a result is stalled at the output.
  a_pc_waits_for_output: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ch.ready) |=> $stable(pc))
    else $error("program counter moved while output was stalled");

  // The divide loop never runs with an exhausted count.
  a_div_count_live: assert property (@(posedge clk) disable iff (rst)
    (upc == U_DIV_STEP) |-> (div_cnt != '0))
    else $error("divider stepped with zero count");

  // A result never carries both a print and a divide-by-zero flag.
  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(print_valid && divide_by_zero))
    else $error("print and divide-by-zero flagged together");
`endif

endmodule
